/* rtl/core/sfp_pkg.sv */
// Shared types and constants of the sensor frame parser.
// Used by the controller, the datapath and the top level; no dependencies.
package sfp_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = 7;
	localparam int BYTE_W      = 8;
	localparam int OUT_W       = 56;

	localparam logic [BYTE_W-1:0] FRAME_HEAD_RST = 8'hEF;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_DEV,
		ST_SYS,
		ST_MSG,
		ST_SEQ,
		ST_LEN,
		ST_PAY,
		ST_CHK,
		ST_RD,
		ST_LOAD
	} sfp_state_t;

	// controller to datapath
	typedef struct packed {
		logic cap_dev;
		logic cap_sys;
		logic cap_msg;
		logic cap_seq;
		logic cap_len;
		logic sum_init;
		logic sum_add;
		logic store_pay;
		logic cnt_clr;
		logic rd_clr;
		logic rd_inc;
		logic out_load;
	} sfp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic head_match;
		logic len_zero;
		logic len_big;
		logic pay_done;
		logic sum_ok;
		logic rd_last;
		logic out_free;
	} sfp_status_t;

endpackage

/* rtl/core/sfp_ctrl.sv */
// Controller state machine of the sensor frame parser.
// Depends on sfp_pkg; drives sfp_datapath through command and status structs.
module sfp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfp_pkg::sfp_status_t sts,
	output sfp_pkg::sfp_cmd_t    cmd
);

	sfp_pkg::sfp_state_t state_q, state_d;
	logic take;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfp_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sfp_pkg::ST_HUNT: if (take && sts.head_match) state_d = sfp_pkg::ST_DEV;
			sfp_pkg::ST_DEV:  if (take) state_d = sfp_pkg::ST_SYS;
			sfp_pkg::ST_SYS:  if (take) state_d = sfp_pkg::ST_MSG;
			sfp_pkg::ST_MSG:  if (take) state_d = sfp_pkg::ST_SEQ;
			sfp_pkg::ST_SEQ:  if (take) state_d = sfp_pkg::ST_LEN;
			sfp_pkg::ST_LEN: begin
				if (take) begin
					if (sts.len_zero) state_d = sfp_pkg::ST_CHK;
					else if (sts.len_big) state_d = sfp_pkg::ST_HUNT;
					else state_d = sfp_pkg::ST_PAY;
				end
			end
			sfp_pkg::ST_PAY: if (take && sts.pay_done) state_d = sfp_pkg::ST_CHK;
			sfp_pkg::ST_CHK: begin
				if (take) state_d = sts.sum_ok ? sfp_pkg::ST_RD : sfp_pkg::ST_HUNT;
			end
			sfp_pkg::ST_RD:   state_d = sfp_pkg::ST_LOAD;
			sfp_pkg::ST_LOAD: begin
				if (sts.out_free) state_d = sts.rd_last ? sfp_pkg::ST_HUNT : sfp_pkg::ST_RD;
			end
			default: state_d = sfp_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sfp_pkg::ST_HUNT: begin
				in_ready     = 1'b1;
				cmd.sum_init = take && sts.head_match;
			end
			sfp_pkg::ST_DEV: begin
				in_ready    = 1'b1;
				cmd.cap_dev = take;
				cmd.sum_add = take;
			end
			sfp_pkg::ST_SYS: begin
				in_ready    = 1'b1;
				cmd.cap_sys = take;
				cmd.sum_add = take;
			end
			sfp_pkg::ST_MSG: begin
				in_ready    = 1'b1;
				cmd.cap_msg = take;
				cmd.sum_add = take;
			end
			sfp_pkg::ST_SEQ: begin
				in_ready    = 1'b1;
				cmd.cap_seq = take;
				cmd.sum_add = take;
			end
			sfp_pkg::ST_LEN: begin
				in_ready    = 1'b1;
				cmd.sum_add = take;
				cmd.cnt_clr = take;
				cmd.cap_len = take && !sts.len_big;
			end
			sfp_pkg::ST_PAY: begin
				in_ready      = 1'b1;
				cmd.sum_add   = take;
				cmd.store_pay = take;
			end
			sfp_pkg::ST_CHK: begin
				in_ready   = 1'b1;
				cmd.rd_clr = take;
			end
			sfp_pkg::ST_RD: begin
				in_ready = 1'b0;
			end
			sfp_pkg::ST_LOAD: begin
				cmd.out_load = sts.out_free;
				cmd.rd_inc   = sts.out_free && !sts.rd_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/sfp_datapath.sv */
// Datapath of the sensor frame parser: header registers, checksum, payload store
// and the output register. Depends on sfp_pkg; commanded by sfp_ctrl.
module sfp_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [sfp_pkg::BYTE_W-1:0]  cfg_wr_data,
	input  logic [sfp_pkg::BYTE_W-1:0]  rx_byte,
	input  sfp_pkg::sfp_cmd_t           cmd,
	output sfp_pkg::sfp_status_t        sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [sfp_pkg::OUT_W-1:0]   out_data,
	output logic                        out_has,
	output logic                        out_last
);

	logic [sfp_pkg::BYTE_W-1:0] head_q;
	logic [sfp_pkg::BYTE_W-1:0] dev_q, sys_q, msg_q, seq_q, sum_q;
	logic [sfp_pkg::LEN_W-1:0]  len_q, cnt_q;
	logic [sfp_pkg::ADDR_W-1:0] rd_idx_q;
	logic [sfp_pkg::BYTE_W-1:0] rd_data_q;
	logic [sfp_pkg::BYTE_W-1:0] mem_q [sfp_pkg::MAX_PAYLOAD];

	logic                        out_valid_q, out_has_q, out_last_q;
	logic [sfp_pkg::BYTE_W-1:0]  o_dev_q, o_sys_q, o_msg_q, o_seq_q, o_byte_q;
	logic [sfp_pkg::LEN_W-1:0]   o_len_q;
	logic [sfp_pkg::ADDR_W-1:0]  o_idx_q;

	logic [sfp_pkg::LEN_W-1:0] cnt_inc, rd_inc_val;

	assign cnt_inc    = cnt_q + sfp_pkg::LEN_W'(1);
	assign rd_inc_val = {1'b0, rd_idx_q} + sfp_pkg::LEN_W'(1);

	assign sts.head_match = (rx_byte == head_q);
	assign sts.len_zero   = (rx_byte == '0);
	assign sts.len_big    = (rx_byte > sfp_pkg::BYTE_W'(sfp_pkg::MAX_PAYLOAD));
	assign sts.pay_done   = (cnt_inc >= len_q);
	assign sts.sum_ok     = (rx_byte == sum_q);
	assign sts.rd_last    = (len_q == '0) || (rd_inc_val == len_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= sfp_pkg::FRAME_HEAD_RST;
			dev_q       <= '0;
			sys_q       <= '0;
			msg_q       <= '0;
			seq_q       <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) head_q <= cfg_wr_data;
			if (cmd.cap_dev) dev_q <= rx_byte;
			if (cmd.cap_sys) sys_q <= rx_byte;
			if (cmd.cap_msg) msg_q <= rx_byte;
			if (cmd.cap_seq) seq_q <= rx_byte;
			if (cmd.cap_len) len_q <= rx_byte[sfp_pkg::LEN_W-1:0];
			if (cmd.sum_init) sum_q <= rx_byte;
			else if (cmd.sum_add) sum_q <= sum_q + rx_byte;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.store_pay) cnt_q <= cnt_inc;
			if (cmd.rd_clr) rd_idx_q <= '0;
			else if (cmd.rd_inc) rd_idx_q <= rd_inc_val[sfp_pkg::ADDR_W-1:0];
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload store and its registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_pay) mem_q[cnt_q[sfp_pkg::ADDR_W-1:0]] <= rx_byte;
		rd_data_q <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_dev_q    <= dev_q;
			o_sys_q    <= sys_q;
			o_msg_q    <= msg_q;
			o_seq_q    <= seq_q;
			o_len_q    <= len_q;
			o_idx_q    <= rd_idx_q;
			o_byte_q   <= (len_q == '0) ? '0 : rd_data_q;
			out_has_q  <= (len_q != '0);
			out_last_q <= sts.rd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_has   = out_has_q;
	assign out_last  = out_last_q;
	assign out_data  = {3'b000, o_byte_q, o_idx_q, o_len_q, o_seq_q, o_msg_q, o_sys_q, o_dev_q};

endmodule

/* rtl/core/sensor_frame_parser.sv */
// Sensor frame parser. The first result follows the checksum byte via ST_RD, ST_LOAD
// and the output register. Throughput: one byte per cycle while s_tvalid is high in
// header, payload and checksum phases; after a good checksum the payload store is read
// out one result at a time (memory read, output register load; longer while m_tready
// is low). Input is held off meanwhile. Reset (arst_n low): parser returns to hunting,
// header/sum clear, frame_head 0xEF. The payload store is not cleared; results only read entries of the current frame.
module sensor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: frame_head
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] device_id, [15:8] system_id, [23:16] message_id, [31:24] sequence_res,
	// [38:32] payload_length, [44:39] byte_index, [52:45] payload_byte, [55:53] zero
	output logic [55:0] m_tdata,
	output logic        m_tuser,   // [0] has_byte
	output logic        m_tlast    // last result of the frame
);

	sfp_pkg::sfp_cmd_t    cmd;
	sfp_pkg::sfp_status_t sts;

	// sequence the phases of a frame and the readout
	sfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold header, checksum and payload; drive the output register
	sfp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx_byte     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_data    (m_tdata),
		.out_has     (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

/* rtl/core/sfp_checker.sv */
// Port-level checks of the sensor frame parser result stream.
// Bound to sensor_frame_parser; no package dependencies.
module sfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// an empty-payload result closes its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("empty result not last");

	// an empty-payload result carries no byte and zero length
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[52:32] == 21'd0)
		else $error("empty result fields not zero");

	// the last byte result sits at the end of the payload
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> ({1'b0, m_tdata[44:39]} + 7'd1) == m_tdata[38:32])
		else $error("last result index mismatch");

endmodule

bind sensor_frame_parser sfp_checker u_sfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
